[src/tmps_pkg.sv]
// Shared constants and types for the triangle maximum path sum block.
`timescale 1ns / 1ps
package tmps_pkg;

   localparam int TMPS_ROWS_MAX    = 32;
   localparam int TMPS_QUEUE_DEPTH = 4;
   localparam int TMPS_RES_DEPTH   = 2;

   localparam int VALUE_W = 16;
   localparam int SUM_W   = 21;
   localparam int ROWS_W  = 6;

   localparam logic [SUM_W-1:0]  SUM_MAX    = {SUM_W{1'b1}};
   localparam logic [ROWS_W-1:0] ROWS_RESET = 6'd15;

   // Position class of one entry, decided when it is accepted.
   typedef struct packed {
      logic first_row;
      logic first_col;
      logic row_end;
      logic final_row;
   } tmps_flags_type;

   localparam int FLAGS_W = $bits(tmps_flags_type);

endpackage

[src/triangle_max_path_sum.sv]
// Top level of the triangle maximum path sum block.
// Entries of a number triangle enter on the req_ queue port, row by row from
// the apex, left to right: an entry is taken at a clock edge with req_push high
// and req_full low. After the last entry of the final row the block offers one
// item on the rsp_ port, the largest apex-to-base path sum; it stays there
// while rsp_empty is low and leaves at an edge with rsp_pop high.
// csr_num_rows sets the row count (0 counts as 1, values above ROWS_MAX count
// as ROWS_MAX); csr_ready is always high. Write it between triangles only.
// Throughput: one entry per clock while the result queue has room, limited
// by the single read and single write of the row memory per entry. A result
// passes the entry queue, the back-end stage and the result queue to rsp_.
// A four-entry queue separates the classifying front end from the memory back
// end; a two-entry result queue sits at the output.
// Reset clears the row and column counters, the running maximum and both
// queues, and sets the row count to 15. No memory clearing pass is needed.
// While the receiver stalls with a full result queue the back end holds, the
// entry queue fills and req_full rises.
`timescale 1ns / 1ps
module triangle_max_path_sum
   import tmps_pkg::*;
#(
   parameter int ROWS_MAX = TMPS_ROWS_MAX
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [ROWS_W-1:0]  csr_num_rows,
   input  logic               req_push,
   output logic               req_full,
   input  logic [VALUE_W-1:0] req_value,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [SUM_W-1:0]   rsp_max_sum
);

   localparam int COL_W = $clog2(ROWS_MAX);
   localparam int Q_W   = VALUE_W + COL_W + FLAGS_W;

   logic               f_push, q_full, q_empty, q_pop;
   logic [VALUE_W-1:0] f_value, b_value;
   logic [COL_W-1:0]   f_col, b_col;
   tmps_flags_type     f_flags, b_flags;
   logic [Q_W-1:0]     q_wr_data, q_rd_data;
   logic               res_push, res_full;
   logic [SUM_W-1:0]   res_max_sum;

   tmps_front #(
      .ROWS_MAX (ROWS_MAX)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_num_rows (csr_num_rows),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_value    (req_value),
      .q_push       (f_push),
      .q_full       (q_full),
      .q_value      (f_value),
      .q_col        (f_col),
      .q_flags      (f_flags)
   );

   assign q_wr_data = {f_value, f_col, f_flags};

   tmps_fifo #(
      .WIDTH (Q_W),
      .DEPTH (TMPS_QUEUE_DEPTH)
   ) u_entry_q (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data (q_wr_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rd_data),
      .empty     (q_empty)
   );

   assign b_value = q_rd_data[Q_W-1 -: VALUE_W];
   assign b_col   = q_rd_data[FLAGS_W +: COL_W];
   assign b_flags = tmps_flags_type'(q_rd_data[FLAGS_W-1:0]);

   tmps_back #(
      .ROWS_MAX (ROWS_MAX)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .q_value     (b_value),
      .q_col       (b_col),
      .q_flags     (b_flags),
      .res_push    (res_push),
      .res_full    (res_full),
      .res_max_sum (res_max_sum)
   );

   tmps_fifo #(
      .WIDTH (SUM_W),
      .DEPTH (TMPS_RES_DEPTH)
   ) u_result_q (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_max_sum),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_max_sum),
      .empty     (rsp_empty)
   );

endmodule

[src/tmps_fifo.sv]
// Small register-based first-in first-out queue.
`timescale 1ns / 1ps
module tmps_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/tmps_front.sv]
// Front end: row count register, entry acceptance and position classification.
`timescale 1ns / 1ps
module tmps_front
   import tmps_pkg::*;
#(
   parameter int ROWS_MAX = TMPS_ROWS_MAX
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [ROWS_W-1:0]           csr_num_rows,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [VALUE_W-1:0]          req_value,
   output logic                        q_push,
   input  logic                        q_full,
   output logic [VALUE_W-1:0]          q_value,
   output logic [$clog2(ROWS_MAX)-1:0] q_col,
   output tmps_flags_type              q_flags
);

   localparam int COL_W = $clog2(ROWS_MAX);
   localparam int CMP_W = (ROWS_W > COL_W + 1) ? ROWS_W : COL_W + 1;

   logic [ROWS_W-1:0] num_rows_ff;
   logic [COL_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [CMP_W-1:0]  rows_wide, last_wide;
   logic [COL_W-1:0]  last_row;
   logic              accept;
   tmps_flags_type    flags;

   assign csr_ready = 1'b1;
   assign req_full  = q_full;
   assign accept    = req_push && !q_full;

   // Clamp the row count to 1..ROWS_MAX and take the index of the last row.
   always_comb begin
      rows_wide = CMP_W'(num_rows_ff);
      last_wide = rows_wide - CMP_W'(1);
      if (num_rows_ff == '0) begin
         last_row = '0;
      end else if (rows_wide > CMP_W'(ROWS_MAX)) begin
         last_row = COL_W'(ROWS_MAX - 1);
      end else begin
         last_row = last_wide[COL_W-1:0];
      end
   end

   always_comb begin
      flags.first_row = (row_ff == '0);
      flags.first_col = (col_ff == '0);
      flags.row_end   = (col_ff >= row_ff);
      flags.final_row = (row_ff >= last_row);
   end

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (accept) begin
         if (flags.row_end) begin
            col_in = '0;
            row_in = flags.final_row ? '0 : row_ff + COL_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= ROWS_RESET;
         row_ff      <= '0;
         col_ff      <= '0;
      end else begin
         if (csr_valid) begin
            num_rows_ff <= csr_num_rows;
         end
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   assign q_push  = accept;
   assign q_value = req_value;
   assign q_col   = col_ff;
   assign q_flags = flags;

endmodule

[src/tmps_back.sv]
// Back end: row memory, best-sum update, running maximum and result push.
`timescale 1ns / 1ps
module tmps_back
   import tmps_pkg::*;
#(
   parameter int ROWS_MAX = TMPS_ROWS_MAX
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_empty,
   output logic                        q_pop,
   input  logic [VALUE_W-1:0]          q_value,
   input  logic [$clog2(ROWS_MAX)-1:0] q_col,
   input  tmps_flags_type              q_flags,
   output logic                        res_push,
   input  logic                        res_full,
   output logic [SUM_W-1:0]            res_max_sum
);

   localparam int COL_W = $clog2(ROWS_MAX);

   logic [SUM_W-1:0]   row_best [ROWS_MAX];
   logic [SUM_W-1:0]   rd_ff;
   logic               byp_ff;
   logic [SUM_W-1:0]   last_best_ff;
   logic               b_valid_ff;
   logic [VALUE_W-1:0] b_value_ff;
   logic [COL_W-1:0]   b_col_ff;
   tmps_flags_type     b_flags_ff;
   logic [SUM_W-1:0]   left_prev_ff;
   logic [SUM_W-1:0]   run_max_ff;

   logic               go, fire;
   logic [SUM_W-1:0]   mem_word, above, addend, best, run_max_in;
   logic [SUM_W:0]     sum;
   logic               emit;

   // Hold the whole back end while the result queue is full.
   assign go    = !res_full;
   assign q_pop = go && !q_empty;
   assign fire  = go && b_valid_ff;

   always_comb begin
      mem_word = byp_ff ? last_best_ff : rd_ff;
      above    = (!b_flags_ff.first_row && !b_flags_ff.row_end) ? mem_word : '0;
      if (b_flags_ff.first_row) begin
         addend = '0;
      end else if (b_flags_ff.first_col) begin
         addend = above;
      end else if (b_flags_ff.row_end) begin
         addend = left_prev_ff;
      end else begin
         addend = (left_prev_ff > above) ? left_prev_ff : above;
      end
      sum  = {1'b0, addend} + (SUM_W + 1)'(b_value_ff);
      best = (sum > (SUM_W + 1)'(SUM_MAX)) ? SUM_MAX : sum[SUM_W-1:0];

      run_max_in = run_max_ff;
      if (b_flags_ff.final_row && (b_flags_ff.first_col || best > run_max_ff)) begin
         run_max_in = best;
      end
      emit = b_flags_ff.final_row && b_flags_ff.row_end;
   end

   assign res_push    = fire && emit;
   assign res_max_sum = run_max_in;

   // Row memory: one write of the finishing item, one registered read of the next.
   always_ff @(posedge clock) begin
      if (fire) begin
         row_best[b_col_ff] <= best;
      end
      if (q_pop) begin
         rd_ff <= row_best[q_col];
      end
   end

   // Forward the sum written in the same cycle as the read of that address.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         byp_ff     <= b_valid_ff && (b_col_ff == q_col);
         b_value_ff <= q_value;
         b_col_ff   <= q_col;
         b_flags_ff <= q_flags;
      end
      if (fire) begin
         last_best_ff <= best;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         left_prev_ff <= '0;
         run_max_ff   <= '0;
      end else begin
         if (go) begin
            b_valid_ff <= !q_empty;
         end
         if (fire) begin
            left_prev_ff <= b_flags_ff.row_end ? '0 : above;
            run_max_ff   <= emit ? '0 : run_max_in;
         end
      end
   end

endmodule

[tb/tb_triangle_max_path_sum.sv]
// Testbench for triangle_max_path_sum: streamed triangles checked against a path-sum predictor.
`timescale 1ns / 1ps
module tb_triangle_max_path_sum
   import tmps_pkg::*;
;

   localparam int TOTAL_ITEMS  = 1920;
   localparam int DRAIN_CYCLES = 12;

   typedef enum int {FILL_RANDOM, FILL_MAX, FILL_ZERO, FILL_EDGES} fill_kind_type;

   // Predicts the maximum path sum of each triangle and holds the sums still due.
   class path_sum_scoreboard;
      logic [ROWS_W-1:0] rows_cfg;
      logic [SUM_W-1:0]  best_row [TMPS_ROWS_MAX];
      int unsigned       row_at;
      int unsigned       col_at;
      logic [SUM_W-1:0]  above_left;
      logic [SUM_W-1:0]  final_max;
      logic [SUM_W-1:0]  expected_sums [$];
      int unsigned       errors;

      function new();
         rows_cfg   = ROWS_RESET;
         row_at     = 0;
         col_at     = 0;
         above_left = '0;
         final_max  = '0;
         errors     = 0;
         foreach (best_row[i]) best_row[i] = '0;
      endfunction

      function void set_rows(input logic [ROWS_W-1:0] n);
         rows_cfg = n;
      endfunction

      function bit at_start();
         return (row_at == 0) && (col_at == 0);
      endfunction

      function int pending();
         return expected_sums.size();
      endfunction

      function logic [SUM_W-1:0] add_sat(input logic [SUM_W-1:0] a,
                                          input logic [VALUE_W-1:0] b);
         logic [SUM_W:0] s;
         s = a + b;
         return (s > SUM_MAX) ? SUM_MAX : s[SUM_W-1:0];
      endfunction

      function void note_entry(input logic [VALUE_W-1:0] v);
         int unsigned      rows_eff;
         int unsigned      c;
         logic [SUM_W-1:0] above;
         logic [SUM_W-1:0] best;
         bit               last_row;
         bit               at_row_end;
         if (rows_cfg == 0)
            rows_eff = 1;
         else if (rows_cfg > TMPS_ROWS_MAX)
            rows_eff = TMPS_ROWS_MAX;
         else
            rows_eff = rows_cfg;
         c = (col_at >= TMPS_ROWS_MAX) ? TMPS_ROWS_MAX - 1 : col_at;
         above = '0;
         if (row_at > 0 && c < row_at) above = best_row[c];
         if (row_at == 0)
            best = v;
         else if (c == 0)
            best = add_sat(above, v);
         else if (c >= row_at)
            best = add_sat(above_left, v);
         else
            best = add_sat((above_left > above) ? above_left : above, v);
         above_left  = above;
         best_row[c] = best;
         last_row    = (row_at + 1 >= rows_eff);
         at_row_end  = (c >= row_at);
         if (last_row && (c == 0 || best > final_max)) final_max = best;
         if (at_row_end) begin
            col_at     = 0;
            above_left = '0;
            if (last_row) begin
               expected_sums.push_back(final_max);
               row_at    = 0;
               final_max = '0;
            end else begin
               row_at = row_at + 1;
            end
         end else begin
            col_at = c + 1;
         end
      endfunction

      function void check_sum(input logic [SUM_W-1:0] actual);
         logic [SUM_W-1:0] want;
         if (expected_sums.size() == 0) begin
            $error("max_sum: no item expected, actual %0d", actual);
            errors++;
            return;
         end
         want = expected_sums.pop_front();
         if (actual !== want) begin
            $error("max_sum mismatch: expected %0d, actual %0d", want, actual);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_valid;
   logic               csr_ready;
   logic [ROWS_W-1:0]  csr_num_rows;
   logic               req_push;
   logic               req_full;
   logic [VALUE_W-1:0] req_value;
   logic               rsp_empty;
   logic               rsp_pop;
   logic [SUM_W-1:0]   rsp_max_sum;

   path_sum_scoreboard sb = new();
   int send_idle_pct = 28;
   int recv_idle_pct = 88;
   int sent_count    = 0;

   triangle_max_path_sum dut (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_num_rows (csr_num_rows),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_value    (req_value),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_max_sum  (rsp_max_sum)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset)
         rsp_pop <= 1'b0;
      else
         rsp_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) sb.check_sum(rsp_max_sum);
   end

   function automatic logic [VALUE_W-1:0] pick_value(input fill_kind_type kind);
      case (kind)
         FILL_MAX:  return '1;
         FILL_ZERO: return '0;
         FILL_EDGES: begin
            case ($urandom_range(0, 3))
               0:       return '0;
               1:       return '1;
               2:       return VALUE_W'($urandom_range(0, 15));
               default: return VALUE_W'(16'hFFFF - $urandom_range(0, 15));
            endcase
         end
         default:   return VALUE_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // Leave req_push high on return so back-to-back items need no second assignment.
   task automatic push_entry(input logic [VALUE_W-1:0] v);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push  <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (req_full);
      sb.note_entry(v);
      sent_count++;
   endtask

   task automatic drain_pipeline();
      req_push <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_rows(input logic [ROWS_W-1:0] n);
      csr_valid    <= 1'b1;
      csr_num_rows <= n;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_rows(n);
   endtask

   task automatic send_triangle(input fill_kind_type kind);
      do push_entry(pick_value(kind)); while (!sb.at_start());
   endtask

   task automatic finish_triangle(input fill_kind_type kind);
      while (!sb.at_start()) push_entry(pick_value(kind));
   endtask

   initial begin
      logic [ROWS_W-1:0] rows_sel;
      fill_kind_type     kind;
      int                big_budget;
      int                n_tri;
      int                n_part;
      reset        <= 1'b1;
      csr_valid    <= 1'b0;
      csr_num_rows <= ROWS_RESET;
      req_push     <= 1'b0;
      req_value    <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Apex under the reset row count, then shrink to two rows mid-triangle.
      push_entry(16'd100);
      drain_pipeline();
      write_rows(6'd2);
      push_entry(16'd200);
      push_entry(16'd300);
      drain_pipeline();
      write_rows(6'd1);
      push_entry(16'd0);
      push_entry(16'hFFFF);
      drain_pipeline();
      write_rows(6'd0);
      push_entry(16'd12345);
      drain_pipeline();
      write_rows(6'd2);
      send_triangle(FILL_MAX);
      drain_pipeline();
      write_rows(6'd3);
      push_entry(16'd5);
      push_entry(16'd9);
      push_entry(16'd1);
      push_entry(16'd1);
      push_entry(16'hFFFF);
      push_entry(16'd7);
      // Cut a five-row triangle short: row two becomes the last one.
      drain_pipeline();
      write_rows(6'd5);
      push_entry(16'd10);
      push_entry(16'd20);
      push_entry(16'd30);
      push_entry(16'd40);
      drain_pipeline();
      write_rows(6'd2);
      push_entry(16'd50);
      push_entry(16'd60);

      big_budget = 2;
      while (sent_count < TOTAL_ITEMS) begin
         if (sent_count < 660) begin
            send_idle_pct = 28;
            recv_idle_pct = 88;
         end else if (sent_count < 1290) begin
            send_idle_pct = 88;
            recv_idle_pct = 28;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         kind  = fill_kind_type'($urandom_range(0, 9) < 6 ? FILL_RANDOM : $urandom_range(0, 3));
         n_tri = $urandom_range(1, 4);
         if (big_budget == 2) begin
            // Largest triangle with every entry at full scale; its sum stays just under SUM_MAX.
            rows_sel = 6'd63;
            kind     = FILL_MAX;
            n_tri    = 1;
            big_budget--;
         end else if (big_budget > 0 && $urandom_range(0, 99) < 4) begin
            rows_sel = ROWS_W'($urandom_range(24, 63));
            n_tri    = 1;
            big_budget--;
         end else if ($urandom_range(0, 99) < 20) begin
            rows_sel = ROWS_W'($urandom_range(9, 16));
            n_tri    = 1;
         end else begin
            rows_sel = ROWS_W'($urandom_range(0, 8));
         end
         drain_pipeline();
         write_rows(rows_sel);
         repeat (n_tri) send_triangle(kind);
         if ($urandom_range(0, 9) == 0) begin
            // Change the row count partway through a triangle.
            n_part = $urandom_range(1, 10);
            repeat (n_part) push_entry(pick_value(kind));
            drain_pipeline();
            write_rows(ROWS_W'($urandom_range(0, 8)));
            finish_triangle(kind);
         end
      end

      drain_pipeline();
      if (sb.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
